// ----- design/acct_pkg.sv -----
package acct_pkg;

	// Collider shape codes.
	localparam logic KIND_BOX    = 1'b0;
	localparam logic KIND_CIRCLE = 1'b1;

	// Control that travels with each word from the geometry stages to the distance stages.
	typedef struct packed {
		logic miss;      // strict box overlap failed
		logic box_pair;  // both colliders are boxes
	} ctl_t;

endpackage

// ----- design/acct_geom.sv -----
module acct_geom #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         a_kind,
	input  logic signed [COORD_BITS-1:0] a_pos_x,
	input  logic signed [COORD_BITS-1:0] a_pos_y,
	input  logic        [COORD_BITS-2:0] a_size_x,
	input  logic        [COORD_BITS-2:0] a_size_y,
	input  logic                         b_kind,
	input  logic signed [COORD_BITS-1:0] b_pos_x,
	input  logic signed [COORD_BITS-1:0] b_pos_y,
	input  logic        [COORD_BITS-2:0] b_size_x,
	input  logic        [COORD_BITS-2:0] b_size_y,
	output logic                         out_valid,
	input  logic                         out_stall,
	output acct_pkg::ctl_t               ctl,
	output logic signed [COORD_BITS+1:0] p_x,
	output logic signed [COORD_BITS+1:0] p_y,
	output logic signed [COORD_BITS+1:0] q_x,
	output logic signed [COORD_BITS+1:0] q_y,
	output logic        [COORD_BITS-1:0] rad
);
	import acct_pkg::*;

	localparam int W  = COORD_BITS;
	localparam int DW = COORD_BITS + 2;

	// Pipeline occupancy and advance enables.
	logic v_s1, v_s2;
	logic adv1, adv2;

	assign adv2     = !v_s2 || !out_stall;
	assign adv1     = !v_s1 || adv2;
	assign in_stall = !adv1;

	// Stage 1 arithmetic: far edges, doubled centres and radius.
	logic signed [W:0]    a_end_x_c, a_end_y_c, b_end_x_c, b_end_y_c;
	logic signed [DW-1:0] a_cen_x_c, a_cen_y_c, b_cen_x_c, b_cen_y_c;
	logic        [W-1:0]  rad_c;

	assign a_end_x_c = $signed({a_pos_x[W-1], a_pos_x}) + $signed({2'b00, a_size_x});
	assign a_end_y_c = $signed({a_pos_y[W-1], a_pos_y}) + $signed({2'b00, a_size_y});
	assign b_end_x_c = $signed({b_pos_x[W-1], b_pos_x}) + $signed({2'b00, b_size_x});
	assign b_end_y_c = $signed({b_pos_y[W-1], b_pos_y}) + $signed({2'b00, b_size_y});

	assign a_cen_x_c = $signed({a_pos_x[W-1], a_pos_x, 1'b0}) + $signed({3'b000, a_size_x});
	assign a_cen_y_c = $signed({a_pos_y[W-1], a_pos_y, 1'b0}) + $signed({3'b000, a_size_y});
	assign b_cen_x_c = $signed({b_pos_x[W-1], b_pos_x, 1'b0}) + $signed({3'b000, b_size_x});
	assign b_cen_y_c = $signed({b_pos_y[W-1], b_pos_y, 1'b0}) + $signed({3'b000, b_size_y});

	// Two circles use the sum of their widths; otherwise the circle's width is the radius.
	always_comb begin
		if (a_kind == KIND_CIRCLE && b_kind == KIND_CIRCLE) begin
			rad_c = {1'b0, a_size_x} + {1'b0, b_size_x};
		end else if (a_kind == KIND_CIRCLE) begin
			rad_c = {1'b0, a_size_x};
		end else begin
			rad_c = {1'b0, b_size_x};
		end
	end

	// Stage 1 registers.
	logic                 a_kind_s1, b_kind_s1;
	logic signed [W-1:0]  a_x_s1, a_y_s1, b_x_s1, b_y_s1;
	logic signed [W:0]    a_end_x_s1, a_end_y_s1, b_end_x_s1, b_end_y_s1;
	logic signed [DW-1:0] a_cen_x_s1, a_cen_y_s1, b_cen_x_s1, b_cen_y_s1;
	logic        [W-1:0]  rad_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			a_kind_s1  <= a_kind;
			b_kind_s1  <= b_kind;
			a_x_s1     <= a_pos_x;
			a_y_s1     <= a_pos_y;
			b_x_s1     <= b_pos_x;
			b_y_s1     <= b_pos_y;
			a_end_x_s1 <= a_end_x_c;
			a_end_y_s1 <= a_end_y_c;
			b_end_x_s1 <= b_end_x_c;
			b_end_y_s1 <= b_end_y_c;
			a_cen_x_s1 <= a_cen_x_c;
			a_cen_y_s1 <= a_cen_y_c;
			b_cen_x_s1 <= b_cen_x_c;
			b_cen_y_s1 <= b_cen_y_c;
			rad_s1     <= rad_c;
		end
	end

	// Stage 2: strict broad phase and clamping of the circle centre onto the box.
	logic                 miss_c;
	logic                 box_is_a;
	logic signed [W-1:0]  box_x, box_y;
	logic signed [W:0]    box_end_x, box_end_y;
	logic signed [DW-1:0] lo_x, lo_y, hi_x, hi_y;
	logic signed [DW-1:0] cc_x, cc_y, cl_x, cl_y, px_c, py_c;

	assign miss_c = ($signed({a_x_s1[W-1], a_x_s1}) >= b_end_x_s1)
		|| (a_end_x_s1 <= $signed({b_x_s1[W-1], b_x_s1}))
		|| ($signed({a_y_s1[W-1], a_y_s1}) >= b_end_y_s1)
		|| (a_end_y_s1 <= $signed({b_y_s1[W-1], b_y_s1}));

	assign box_is_a  = (a_kind_s1 == KIND_BOX);
	assign box_x     = box_is_a ? a_x_s1 : b_x_s1;
	assign box_y     = box_is_a ? a_y_s1 : b_y_s1;
	assign box_end_x = box_is_a ? a_end_x_s1 : b_end_x_s1;
	assign box_end_y = box_is_a ? a_end_y_s1 : b_end_y_s1;
	assign lo_x      = $signed({box_x[W-1], box_x, 1'b0});
	assign lo_y      = $signed({box_y[W-1], box_y, 1'b0});
	assign hi_x      = $signed({box_end_x, 1'b0});
	assign hi_y      = $signed({box_end_y, 1'b0});

	// The second point is the second collider's centre when it is a circle, otherwise the first collider's centre.
	assign cc_x = (b_kind_s1 == KIND_CIRCLE) ? b_cen_x_s1 : a_cen_x_s1;
	assign cc_y = (b_kind_s1 == KIND_CIRCLE) ? b_cen_y_s1 : a_cen_y_s1;

	always_comb begin
		if (cc_x < lo_x) begin
			cl_x = lo_x;
		end else if (cc_x > hi_x) begin
			cl_x = hi_x;
		end else begin
			cl_x = cc_x;
		end
		if (cc_y < lo_y) begin
			cl_y = lo_y;
		end else if (cc_y > hi_y) begin
			cl_y = hi_y;
		end else begin
			cl_y = cc_y;
		end
	end

	// For two circles the first point is the first centre, otherwise the clamped point.
	assign px_c = (a_kind_s1 == KIND_CIRCLE && b_kind_s1 == KIND_CIRCLE) ? a_cen_x_s1 : cl_x;
	assign py_c = (a_kind_s1 == KIND_CIRCLE && b_kind_s1 == KIND_CIRCLE) ? a_cen_y_s1 : cl_y;

	// Stage 2 registers.
	ctl_t                 ctl_s2;
	logic signed [DW-1:0] px_s2, py_s2, qx_s2, qy_s2;
	logic        [W-1:0]  rad_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			ctl_s2.miss     <= miss_c;
			ctl_s2.box_pair <= (a_kind_s1 == KIND_BOX) && (b_kind_s1 == KIND_BOX);
			px_s2           <= px_c;
			py_s2           <= py_c;
			qx_s2           <= cc_x;
			qy_s2           <= cc_y;
			rad_s2          <= rad_s1;
		end
	end

	assign out_valid = v_s2;
	assign ctl       = ctl_s2;
	assign p_x       = px_s2;
	assign p_y       = py_s2;
	assign q_x       = qx_s2;
	assign q_y       = qy_s2;
	assign rad       = rad_s2;

endmodule

// ----- design/acct_dist.sv -----
module acct_dist #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  acct_pkg::ctl_t               ctl,
	input  logic signed [COORD_BITS+1:0] p_x,
	input  logic signed [COORD_BITS+1:0] p_y,
	input  logic signed [COORD_BITS+1:0] q_x,
	input  logic signed [COORD_BITS+1:0] q_y,
	input  logic        [COORD_BITS-1:0] rad,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit
);
	import acct_pkg::*;

	localparam int W  = COORD_BITS;
	localparam int DW = COORD_BITS + 2;
	localparam int SW = 2 * DW;

	// Pipeline occupancy and advance enables.
	logic v_s3, v_s4, v_s5;
	logic adv3, adv4, adv5;

	assign adv5     = !v_s5 || !out_stall;
	assign adv4     = !v_s4 || adv5;
	assign adv3     = !v_s3 || adv4;
	assign in_stall = !adv3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv3) begin
				v_s3 <= in_valid;
			end
			if (adv4) begin
				v_s4 <= v_s3;
			end
			if (adv5) begin
				v_s5 <= v_s4;
			end
		end
	end

	// Stage 3: absolute differences along each axis.
	logic signed [DW:0]   dx_c, dy_c;
	logic        [DW-1:0] mx_c, my_c;

	assign dx_c = $signed({p_x[DW-1], p_x}) - $signed({q_x[DW-1], q_x});
	assign dy_c = $signed({p_y[DW-1], p_y}) - $signed({q_y[DW-1], q_y});

	always_comb begin
		logic signed [DW:0] nx, ny;
		nx   = -dx_c;
		ny   = -dy_c;
		mx_c = dx_c[DW] ? nx[DW-1:0] : dx_c[DW-1:0];
		my_c = dy_c[DW] ? ny[DW-1:0] : dy_c[DW-1:0];
	end

	ctl_t          ctl_s3;
	logic [DW-1:0] mx_s3, my_s3;
	logic [W-1:0]  rad_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			ctl_s3 <= ctl;
			mx_s3  <= mx_c;
			my_s3  <= my_c;
			rad_s3 <= rad;
		end
	end

	// Stage 4: the three squares.
	ctl_t          ctl_s4;
	logic [SW-1:0] sx_s4, sy_s4;
	logic [2*W-1:0] rr_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			ctl_s4 <= ctl_s3;
			sx_s4  <= SW'(mx_s3) * SW'(mx_s3);
			sy_s4  <= SW'(my_s3) * SW'(my_s3);
			rr_s4  <= (2*W)'(rad_s3) * (2*W)'(rad_s3);
		end
	end

	// Stage 5: squared distance against squared radius, all strict; a box pair hits on the broad phase alone.
	logic [SW:0] d2_c;
	logic        hit_c;

	assign d2_c  = {1'b0, sx_s4} + {1'b0, sy_s4};
	assign hit_c = !ctl_s4.miss && (ctl_s4.box_pair || (d2_c < (SW+1)'(rr_s4)));

	logic hit_s5;

	always_ff @(posedge clk) begin
		if (adv5) begin
			hit_s5 <= hit_c;
		end
	end

	assign out_valid = v_s5;
	assign hit       = hit_s5;

endmodule

// ----- design/aabb_circle_collision_test.sv -----
// Pair hit test for 2D boxes and circles, five register stages.
// Throughput: one word per cycle; a stall at the output holds the full stages in place
// while empty stages keep moving, so bubbles close up.
// The stage that forms the three squares sets the depth of the critical path.
// Reset (arst_n, asynchronous) clears the valid bits only; no data state is kept.
module aabb_circle_collision_test #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         a_kind,
	input  logic signed [COORD_BITS-1:0] a_pos_x,
	input  logic signed [COORD_BITS-1:0] a_pos_y,
	input  logic        [COORD_BITS-2:0] a_size_x,
	input  logic        [COORD_BITS-2:0] a_size_y,
	input  logic                         b_kind,
	input  logic signed [COORD_BITS-1:0] b_pos_x,
	input  logic signed [COORD_BITS-1:0] b_pos_y,
	input  logic        [COORD_BITS-2:0] b_size_x,
	input  logic        [COORD_BITS-2:0] b_size_y,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit
);
	import acct_pkg::*;

	// Link between the geometry stages and the distance stages.
	logic                         mid_valid;
	logic                         mid_stall;
	ctl_t                         mid_ctl;
	logic signed [COORD_BITS+1:0] mid_px, mid_py, mid_qx, mid_qy;
	logic        [COORD_BITS-1:0] mid_rad;

	// Broad phase and clamping.
	acct_geom #(
		.COORD_BITS(COORD_BITS)
	) u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.a_kind   (a_kind),
		.a_pos_x  (a_pos_x),
		.a_pos_y  (a_pos_y),
		.a_size_x (a_size_x),
		.a_size_y (a_size_y),
		.b_kind   (b_kind),
		.b_pos_x  (b_pos_x),
		.b_pos_y  (b_pos_y),
		.b_size_x (b_size_x),
		.b_size_y (b_size_y),
		.out_valid(mid_valid),
		.out_stall(mid_stall),
		.ctl      (mid_ctl),
		.p_x      (mid_px),
		.p_y      (mid_py),
		.q_x      (mid_qx),
		.q_y      (mid_qy),
		.rad      (mid_rad)
	);

	// Squared distance compare and output register.
	acct_dist #(
		.COORD_BITS(COORD_BITS)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (mid_valid),
		.in_stall (mid_stall),
		.ctl      (mid_ctl),
		.p_x      (mid_px),
		.p_y      (mid_py),
		.q_x      (mid_qx),
		.q_y      (mid_qy),
		.rad      (mid_rad),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit      (hit)
	);

endmodule
